/* sv/ppte_pkg.sv */
`default_nettype none

package ppte_pkg;

    localparam int MAX_SEGMENTS = 16;
    localparam int MAX_COEFFS = 8;
    localparam int NUM_AXES = 3;

    localparam int RAM_DEPTH = MAX_SEGMENTS * MAX_COEFFS;
    localparam int ADDR_W = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    // Slot counter must hold MAX_COEFFS itself
    localparam int CNT_W = $clog2(MAX_COEFFS + 1);

    localparam int SEG_W = 4;
    localparam int AXIS_W = 2;
    localparam int SLOT_IN_W = 3;
    localparam int NC_W = 4;
    localparam int COEFF_W = 32;
    localparam int TIME_W = 24;
    localparam int ACC_W = 48;
    localparam int POS_W = 32;

    localparam logic [NC_W-1:0] NUM_COEFFS_RESET = 4'd6;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ0,
        ST_LOAD0,
        ST_MUL,
        ST_ADD,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic wr;        // store one coefficient from the input ports
        logic start;     // latch segment and time, clear accumulators
        logic rd;        // read the next slot of all three axis tables
        logic load_c0;   // accumulator takes the leading coefficient
        logic mul;       // register the partial products
        logic add;       // floor, add coefficient, saturate
        logic load_out;  // final saturation into the output registers
    } cmd_t;

    typedef struct packed {
        logic seg_ok;    // segment on the input ports is inside the table
        logic single;    // polynomial has only the constant term
        logic last;      // the coefficient being added is the last one
    } sts_t;

endpackage

`default_nettype wire

/* sv/ppte_ram.sv */
`default_nettype none

module ppte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* sv/ppte_horner.sv */
`default_nettype none

module ppte_horner (
    input  wire logic                          clk,
    input  wire ppte_pkg::cmd_t                cmd,
    input  wire logic [ppte_pkg::COEFF_W-1:0]  coeff,
    input  wire logic [ppte_pkg::TIME_W-1:0]   time_val,
    output logic      [ppte_pkg::ACC_W-1:0]    acc,
    output logic                               ovf
);

    localparam int LO_W = ppte_pkg::TIME_W;
    localparam int HI_W = ppte_pkg::ACC_W - LO_W;
    localparam int PHI_W = HI_W + ppte_pkg::TIME_W + 1;
    localparam int PLO_W = LO_W + ppte_pkg::TIME_W;
    localparam int PROD_W = PHI_W + LO_W;
    localparam int FRAC = 16;
    localparam int SUM_W = PROD_W - FRAC + 1;

    logic signed [ppte_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic                              ovf_reg, ovf_next;
    logic signed [PHI_W-1:0]           p_hi_reg, p_hi_next;
    logic        [PLO_W-1:0]           p_lo_reg, p_lo_next;

    logic signed [PROD_W-1:0]          prod;
    logic signed [SUM_W-1:0]           sum;
    logic signed [ppte_pkg::ACC_W-1:0] sum_sat;
    logic                              sum_ovf;

    always_comb
    begin
        // Split the accumulator: signed upper half times t, unsigned lower half times t
        p_hi_next = PHI_W'($signed(acc_reg[ppte_pkg::ACC_W-1:LO_W]))
                  * PHI_W'($signed({1'b0, time_val}));
        p_lo_next = PLO_W'(acc_reg[LO_W-1:0]) * PLO_W'(time_val);

        prod = $signed({p_hi_reg, {LO_W{1'b0}}}) + $signed({{(PROD_W-PLO_W){1'b0}}, p_lo_reg});
        // Dropping the fraction bits floors toward minus infinity
        sum = $signed({prod[PROD_W-1], prod[PROD_W-1:FRAC]})
            + $signed({{(SUM_W-ppte_pkg::COEFF_W){coeff[ppte_pkg::COEFF_W-1]}}, coeff});

        sum_ovf = (sum[SUM_W-1:ppte_pkg::ACC_W-1]
                   != {(SUM_W-ppte_pkg::ACC_W+1){sum[SUM_W-1]}});
        if (!sum_ovf)
        begin
            sum_sat = sum[ppte_pkg::ACC_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            sum_sat = {1'b1, {(ppte_pkg::ACC_W-1){1'b0}}};
        end
        else
        begin
            sum_sat = {1'b0, {(ppte_pkg::ACC_W-1){1'b1}}};
        end

        acc_next = acc_reg;
        ovf_next = ovf_reg;
        priority if (cmd.start)
        begin
            acc_next = '0;
            ovf_next = 1'b0;
        end
        else if (cmd.load_c0)
        begin
            acc_next = {{(ppte_pkg::ACC_W-ppte_pkg::COEFF_W){coeff[ppte_pkg::COEFF_W-1]}}, coeff};
        end
        else if (cmd.add)
        begin
            acc_next = sum_sat;
            ovf_next = ovf_reg | sum_ovf;
        end
        else
        begin
            acc_next = acc_reg;
            ovf_next = ovf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        ovf_reg <= ovf_next;
        if (cmd.mul)
        begin
            p_hi_reg <= p_hi_next;
            p_lo_reg <= p_lo_next;
        end
    end

    assign acc = acc_reg;
    assign ovf = ovf_reg;

endmodule

`default_nettype wire

/* sv/ppte_datapath.sv */
`default_nettype none

module ppte_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ppte_pkg::cmd_t                  cmd,
    output ppte_pkg::sts_t                       sts,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ppte_pkg::NC_W-1:0]       cfg_wr_data,
    input  wire logic [ppte_pkg::SEG_W-1:0]      segment,
    input  wire logic [ppte_pkg::AXIS_W-1:0]     axis,
    input  wire logic [ppte_pkg::SLOT_IN_W-1:0]  coeff_index,
    input  wire logic [ppte_pkg::COEFF_W-1:0]    coeff_value,
    input  wire logic [ppte_pkg::TIME_W-1:0]     time_value,
    output logic      [ppte_pkg::POS_W-1:0]      pos_x,
    output logic      [ppte_pkg::POS_W-1:0]      pos_y,
    output logic      [ppte_pkg::POS_W-1:0]      pos_z,
    output logic                                 overflow
);

    localparam int CW = ppte_pkg::CNT_W;
    localparam int AW = ppte_pkg::ADDR_W;
    localparam int NA = ppte_pkg::NUM_AXES;
    localparam int PW = ppte_pkg::POS_W;
    localparam int ACW = ppte_pkg::ACC_W;

    logic [ppte_pkg::NC_W-1:0]    num_coeffs_reg, num_coeffs_next;
    logic [CW-1:0]                slot_reg, slot_next;
    logic [ppte_pkg::SEG_W-1:0]   seg_reg, seg_next;
    logic [ppte_pkg::TIME_W-1:0]  time_reg, time_next;
    logic [PW-1:0]                pos_x_reg, pos_x_next;
    logic [PW-1:0]                pos_y_reg, pos_y_next;
    logic [PW-1:0]                pos_z_reg, pos_z_next;
    logic                         ovf_out_reg, ovf_out_next;

    logic [CW-1:0]                n_eff;
    logic [AW-1:0]                wr_addr;
    logic [AW-1:0]                rd_addr;
    logic                         wr_in_range;
    logic [NA-1:0]                wr_en;
    logic [ppte_pkg::COEFF_W-1:0] rd_data [NA];
    logic [ACW-1:0]               acc [NA];
    logic [NA-1:0]                lane_ovf;
    logic [PW-1:0]                sat_val [NA];
    logic [NA-1:0]                sat_ovf;

    // Clamp the coefficient count to 1..MAX_COEFFS
    always_comb
    begin
        priority if (num_coeffs_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (32'(num_coeffs_reg) > 32'(ppte_pkg::MAX_COEFFS))
        begin
            n_eff = CW'(ppte_pkg::MAX_COEFFS);
        end
        else
        begin
            n_eff = CW'(num_coeffs_reg);
        end
    end

    assign sts.seg_ok = 32'(segment) < 32'(ppte_pkg::MAX_SEGMENTS);
    assign sts.single = (n_eff == CW'(1));
    assign sts.last = (slot_reg == n_eff);

    assign wr_in_range = sts.seg_ok
                       && (32'(coeff_index) < 32'(ppte_pkg::MAX_COEFFS));
    assign wr_addr = AW'(32'(segment) * 32'(ppte_pkg::MAX_COEFFS) + 32'(coeff_index));
    assign rd_addr = AW'(32'(seg_reg) * 32'(ppte_pkg::MAX_COEFFS) + 32'(slot_reg));

    for (genvar a = 0; a < NA; a++)
    begin : g_axis
        // Axis codes beyond z select no table and drop the request
        assign wr_en[a] = cmd.wr && wr_in_range && (32'(axis) == a);

        ppte_ram #(
            .WIDTH (ppte_pkg::COEFF_W),
            .DEPTH (ppte_pkg::RAM_DEPTH)
        ) u_ram (
            .clk     (clk),
            .wr_en   (wr_en[a]),
            .wr_addr (wr_addr),
            .wr_data (coeff_value),
            .rd_en   (cmd.rd),
            .rd_addr (rd_addr),
            .rd_data (rd_data[a])
        );

        ppte_horner u_horner (
            .clk      (clk),
            .cmd      (cmd),
            .coeff    (rd_data[a]),
            .time_val (time_reg),
            .acc      (acc[a]),
            .ovf      (lane_ovf[a])
        );

        always_comb
        begin
            sat_ovf[a] = (acc[a][ACW-1:PW-1] != {(ACW-PW+1){acc[a][ACW-1]}});
            if (!sat_ovf[a])
            begin
                sat_val[a] = acc[a][PW-1:0];
            end
            else if (acc[a][ACW-1])
            begin
                sat_val[a] = {1'b1, {(PW-1){1'b0}}};
            end
            else
            begin
                sat_val[a] = {1'b0, {(PW-1){1'b1}}};
            end
        end
    end

    always_comb
    begin
        num_coeffs_next = cfg_wr_en ? cfg_wr_data : num_coeffs_reg;

        slot_next = slot_reg;
        if (cmd.start)
        begin
            slot_next = '0;
        end
        else if (cmd.rd)
        begin
            slot_next = slot_reg + CW'(1);
        end

        seg_next = cmd.start ? segment : seg_reg;
        time_next = cmd.start ? time_value : time_reg;

        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        pos_z_next = pos_z_reg;
        ovf_out_next = ovf_out_reg;
        if (cmd.load_out)
        begin
            pos_x_next = sat_val[0];
            pos_y_next = sat_val[1];
            pos_z_next = sat_val[2];
            ovf_out_next = (|lane_ovf) | (|sat_ovf);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_coeffs_reg <= ppte_pkg::NUM_COEFFS_RESET;
            slot_reg <= '0;
        end
        else
        begin
            num_coeffs_reg <= num_coeffs_next;
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg <= seg_next;
        time_reg <= time_next;
        pos_x_reg <= pos_x_next;
        pos_y_reg <= pos_y_next;
        pos_z_reg <= pos_z_next;
        ovf_out_reg <= ovf_out_next;
    end

    assign pos_x = pos_x_reg;
    assign pos_y = pos_y_reg;
    assign pos_z = pos_z_reg;
    assign overflow = ovf_out_reg;

endmodule

`default_nettype wire

/* sv/ppte_ctrl.sv */
`default_nettype none

module ppte_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic           req_type,
    output logic                out_valid,
    input  wire logic           out_stall,
    input  wire ppte_pkg::sts_t sts,
    output ppte_pkg::cmd_t      cmd
);

    ppte_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;

    assign in_stall = (state_reg != ppte_pkg::ST_IDLE);
    assign accept = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;

        unique case (state_reg)
            ppte_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == ppte_pkg::REQ_WRITE)
                    begin
                        cmd.wr = 1'b1;
                    end
                    else
                    begin
                        cmd.start = 1'b1;
                        // Out-of-table segment: skip straight to a zero result
                        state_next = sts.seg_ok ? ppte_pkg::ST_READ0 : ppte_pkg::ST_FINISH;
                    end
                end
            end
            ppte_pkg::ST_READ0:
            begin
                cmd.rd = 1'b1;
                state_next = ppte_pkg::ST_LOAD0;
            end
            ppte_pkg::ST_LOAD0:
            begin
                cmd.load_c0 = 1'b1;
                if (sts.single)
                begin
                    state_next = ppte_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.rd = 1'b1;
                    state_next = ppte_pkg::ST_MUL;
                end
            end
            ppte_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = ppte_pkg::ST_ADD;
            end
            ppte_pkg::ST_ADD:
            begin
                cmd.add = 1'b1;
                if (sts.last)
                begin
                    state_next = ppte_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.rd = 1'b1;
                    state_next = ppte_pkg::ST_MUL;
                end
            end
            ppte_pkg::ST_FINISH:
            begin
                // Hold until the output register is free or drains this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next = ppte_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ppte_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppte_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* sv/piecewise_poly_trajectory_eval_top.sv */
`default_nettype none

// Channel | Handshake            | Payload
// --------+----------------------+----------------------------------------------
// in      | in_valid / in_stall  | req_type segment axis coeff_index
//         |                      | coeff_value time_value
// out     | out_valid / out_stall| pos_x pos_y pos_z overflow
// cfg     | cfg_wr_en            | cfg_wr_data (num_coeffs)
//
// A coefficient write gives no result.
// An evaluate loads the leading coefficient, then runs a Horner step for each
// further one; in_stall holds off new requests until its result is loaded. Each
// step is a registered split multiply, then floor, add and 48-bit saturation.
// Reset clears the controller and sets num_coeffs to 6; the coefficient tables
// are not cleared. While out is stalled, writes are still taken, and a finished
// evaluate holds in the datapath until the output register frees.

module piecewise_poly_trajectory_eval_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ppte_pkg::NC_W-1:0]       cfg_wr_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            req_type,
    input  wire logic [ppte_pkg::SEG_W-1:0]      segment,
    input  wire logic [ppte_pkg::AXIS_W-1:0]     axis,
    input  wire logic [ppte_pkg::SLOT_IN_W-1:0]  coeff_index,
    input  wire logic [ppte_pkg::COEFF_W-1:0]    coeff_value,
    input  wire logic [ppte_pkg::TIME_W-1:0]     time_value,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [ppte_pkg::POS_W-1:0]      pos_x,
    output logic      [ppte_pkg::POS_W-1:0]      pos_y,
    output logic      [ppte_pkg::POS_W-1:0]      pos_z,
    output logic                                 overflow
);

    ppte_pkg::cmd_t cmd;
    ppte_pkg::sts_t sts;

    ppte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ppte_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .segment     (segment),
        .axis        (axis),
        .coeff_index (coeff_index),
        .coeff_value (coeff_value),
        .time_value  (time_value),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .overflow    (overflow)
    );

endmodule

`default_nettype wire
